// File: hw/rtl/text_glyph_renderer_macros.svh
// Assertion macros used by the checker of the glyph renderer.
`ifndef TEXT_GLYPH_RENDERER_MACROS_SVH
`define TEXT_GLYPH_RENDERER_MACROS_SVH

// Same-cycle implication, sampled on aclk, quiet while in reset.
`define TGR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while in reset.
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tgr_pkg.sv
package tgr_pkg;

    localparam int GLYPH_W = 8;
    localparam logic [11:0] EXT_MAX = 12'hFFF;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic FUNC_RENDER   = 1'b0;
    localparam logic FUNC_FONT_WR  = 1'b1;

    localparam logic CFG_DRAW_ENABLE = 1'b0;
    localparam logic CFG_INK_COLOR   = 1'b1;

    typedef enum logic [1:0] {
        KIND_FONT_WR,
        KIND_EXTENT,
        KIND_GLYPH
    } tgr_kind_t;

    // One queued job for the back end.
    typedef struct packed {
        tgr_kind_t   kind;
        logic [10:0] addr;   // font address, or glyph base address
        logic [7:0]  data;   // font byte for a font write
        logic [10:0] px;
        logic [10:0] py;     // y of the glyph's top row
        logic [11:0] ext_w;
        logic [11:0] ext_h;
    } tgr_entry_t;

endpackage

// File: hw/rtl/tgr_ram.sv
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tgr_queue.sv
module tgr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tgr_pkg::tgr_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output tgr_pkg::tgr_entry_t head,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tgr_pkg::tgr_entry_t slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/tgr_front.sv
module tgr_front #(
    parameter int GLYPH_HEIGHT = 8,
    parameter int MAX_COLUMNS  = 256,
    parameter int MAX_ROWS     = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  logic [31:0]         s_tdata,
    input  logic                draw_enable,
    input  logic                q_full,
    output logic                push,
    output tgr_pkg::tgr_entry_t push_entry
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int WC_W  = (COL_W + 3 > 13) ? COL_W + 3 : 13;
    localparam int HC_RAW = ROW_W + 1 + $clog2(GLYPH_HEIGHT + 1);
    localparam int HC_W  = (HC_RAW > 13) ? HC_RAW : 13;
    localparam int CB_W  = 8 + $clog2(GLYPH_HEIGHT + 1);

    logic [COL_W-1:0] col_reg, col_next, col_eff, col_upd;
    logic [ROW_W-1:0] row_reg, row_next, row_eff, row_upd;
    logic [11:0]      ext_w_reg, ext_w_next, ext_w_eff;
    logic [11:0]      ext_h_reg, ext_h_next, ext_h_eff;
    logic             stopped_reg, stopped_next, stopped_eff;

    logic             func, first;
    logic [7:0]       char_code, font_data;
    logic [10:0]      font_addr;
    logic             accept, printable, counts;
    logic [COL_W:0]   tab_col;
    logic [WC_W-1:0]  w_cand;
    logic [HC_W-1:0]  h_cand;
    logic [11:0]      w_sat, h_sat;

    assign func      = s_tuser;
    assign first     = s_tdata[0];
    assign char_code = s_tdata[8:1];
    assign font_addr = s_tdata[19:9];
    assign font_data = s_tdata[27:20];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    // a new string starts from a clean slate
    assign col_eff     = first ? '0 : col_reg;
    assign row_eff     = first ? '0 : row_reg;
    assign ext_w_eff   = first ? '0 : ext_w_reg;
    assign ext_h_eff   = first ? '0 : ext_h_reg;
    assign stopped_eff = first ? 1'b0 : stopped_reg;

    assign tab_col = ({1'b0, col_eff} | (COL_W + 1)'(3)) + 1'b1;

    always_comb begin
        col_upd   = col_eff;
        row_upd   = row_eff;
        printable = 1'b0;
        case (char_code)
            tgr_pkg::CH_LF: begin
                if (row_eff < ROW_W'(MAX_ROWS - 1)) begin
                    row_upd = row_eff + 1'b1;
                end
                col_upd = '0;
            end
            tgr_pkg::CH_CR: begin
                col_upd = col_eff;
            end
            tgr_pkg::CH_TAB: begin
                if (tab_col > (COL_W + 1)'(MAX_COLUMNS)) begin
                    col_upd = COL_W'(MAX_COLUMNS);
                end else begin
                    col_upd = tab_col[COL_W-1:0];
                end
            end
            default: begin
                if (col_eff < COL_W'(MAX_COLUMNS)) begin
                    col_upd = col_eff + 1'b1;
                end
                printable = 1'b1;
            end
        endcase
    end

    assign counts = !stopped_eff && (char_code != tgr_pkg::CH_NUL);

    assign w_cand = WC_W'(col_upd) * WC_W'(tgr_pkg::GLYPH_W);
    assign h_cand = (HC_W'(row_upd) + 1'b1) * HC_W'(GLYPH_HEIGHT);
    assign w_sat  = (w_cand > WC_W'(tgr_pkg::EXT_MAX)) ? tgr_pkg::EXT_MAX : w_cand[11:0];
    assign h_sat  = (h_cand > HC_W'(tgr_pkg::EXT_MAX)) ? tgr_pkg::EXT_MAX : h_cand[11:0];

    always_comb begin
        col_next     = col_eff;
        row_next     = row_eff;
        ext_w_next   = ext_w_eff;
        ext_h_next   = ext_h_eff;
        stopped_next = stopped_eff;
        if (counts) begin
            col_next   = col_upd;
            row_next   = row_upd;
            ext_w_next = (w_sat > ext_w_eff) ? w_sat : ext_w_eff;
            ext_h_next = (h_sat > ext_h_eff) ? h_sat : ext_h_eff;
        end else if (!stopped_eff) begin
            stopped_next = 1'b1;
        end
    end

    always_comb begin
        push_entry.kind  = tgr_pkg::KIND_EXTENT;
        push_entry.addr  = 11'(CB_W'(char_code) * CB_W'(GLYPH_HEIGHT));
        push_entry.data  = font_data;
        push_entry.px    = 11'((WC_W'(col_next) - 1'b1) * WC_W'(tgr_pkg::GLYPH_W));
        push_entry.py    = 11'(HC_W'(row_next) * HC_W'(GLYPH_HEIGHT));
        push_entry.ext_w = ext_w_next;
        push_entry.ext_h = ext_h_next;
        if (func == tgr_pkg::FUNC_FONT_WR) begin
            push_entry.kind = tgr_pkg::KIND_FONT_WR;
            push_entry.addr = font_addr;
        end else if (counts && printable && draw_enable) begin
            push_entry.kind = tgr_pkg::KIND_GLYPH;
        end
    end

    // font writes leave the text state alone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            ext_w_reg   <= '0;
            ext_h_reg   <= '0;
            stopped_reg <= 1'b0;
        end else if (accept && func == tgr_pkg::FUNC_RENDER) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            ext_w_reg   <= ext_w_next;
            ext_h_reg   <= ext_h_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: hw/rtl/tgr_back.sv
module tgr_back #(
    parameter int GLYPH_HEIGHT = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgr_pkg::tgr_entry_t head,
    input  logic                q_empty,
    output logic                pop,
    input  logic [31:0]         ink_color,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [87:0]         m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int RR_W = $clog2(GLYPH_HEIGHT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    state_t              state_reg, state_next;
    tgr_pkg::tgr_entry_t cur_reg, cur_next;
    logic [RR_W-1:0]     rd_row_reg, rd_row_next;
    logic [RR_W-1:0]     out_row_reg, out_row_next;
    logic                pend_reg, pend_next;

    logic                m_valid_reg, m_valid_next;
    logic [10:0]         px_reg, px_next;
    logic [10:0]         py_reg, py_next;
    logic [7:0]          bits_reg, bits_next;
    logic                rvalid_reg, rvalid_next;
    logic [11:0]         ew_reg, ew_next;
    logic [11:0]         eh_reg, eh_next;
    logic [31:0]         color_reg, color_next;
    logic                last_reg, last_next;

    logic                out_free, load, issue, ram_we, rd_en;
    logic [10:0]         rd_addr;
    logic [7:0]          rd_data;

    tgr_ram #(
        .WIDTH(8),
        .DEPTH(2048)
    ) u_font (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (head.addr),
        .wr_data (head.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign load     = (state_reg == ST_DRAW) && pend_reg && out_free;
    // read the next row once the read register is free or being drained
    assign issue    = (state_reg == ST_DRAW) && (rd_row_reg != RR_W'(GLYPH_HEIGHT))
                      && (!pend_reg || out_free);
    assign rd_en    = issue;
    assign rd_addr  = cur_reg.addr + 11'(rd_row_reg);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        rd_row_next  = rd_row_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_tready;
        px_next      = px_reg;
        py_next      = py_reg;
        bits_next    = bits_reg;
        rvalid_next  = rvalid_reg;
        ew_next      = ew_reg;
        eh_next      = eh_reg;
        color_next   = color_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    case (head.kind)
                        tgr_pkg::KIND_FONT_WR: begin
                            ram_we = 1'b1;
                            pop    = 1'b1;
                        end
                        tgr_pkg::KIND_EXTENT: begin
                            if (out_free) begin
                                pop          = 1'b1;
                                m_valid_next = 1'b1;
                                px_next      = '0;
                                py_next      = '0;
                                bits_next    = '0;
                                rvalid_next  = 1'b0;
                                ew_next      = head.ext_w;
                                eh_next      = head.ext_h;
                                color_next   = ink_color;
                                last_next    = 1'b1;
                            end
                        end
                        tgr_pkg::KIND_GLYPH: begin
                            pop          = 1'b1;
                            cur_next     = head;
                            rd_row_next  = '0;
                            out_row_next = '0;
                            pend_next    = 1'b0;
                            state_next   = ST_DRAW;
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                if (issue) begin
                    rd_row_next = rd_row_reg + 1'b1;
                end
                pend_next = issue || (pend_reg && !out_free);
                if (load) begin
                    m_valid_next = 1'b1;
                    px_next      = cur_reg.px;
                    py_next      = cur_reg.py + 11'(out_row_reg);
                    bits_next    = rd_data;
                    rvalid_next  = 1'b1;
                    ew_next      = cur_reg.ext_w;
                    eh_next      = cur_reg.ext_h;
                    color_next   = ink_color;
                    last_next    = (out_row_reg == RR_W'(GLYPH_HEIGHT - 1));
                    out_row_next = out_row_reg + 1'b1;
                    if (out_row_reg == RR_W'(GLYPH_HEIGHT - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg     <= cur_next;
        rd_row_reg  <= rd_row_next;
        out_row_reg <= out_row_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        bits_reg    <= bits_next;
        rvalid_reg  <= rvalid_next;
        ew_reg      <= ew_next;
        eh_reg      <= eh_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, color_reg, eh_reg, ew_reg, bits_reg, py_reg, px_reg};
    assign m_tuser  = rvalid_reg;
    assign m_tlast  = last_reg;

endmodule

// File: hw/rtl/text_glyph_renderer.sv
// 8-pixel-wide bitmap font text renderer. A front end takes one input word per
// cycle while the queue is not full, tracks the text cursor and extents, and
// queues a job in a four-entry queue; a back end runs the jobs against a
// 2048 x 8 font memory. A font write is taken straight from the queue; a
// control/ignored character gives a single extent-only result. A drawn glyph
// takes the job, starts the first font memory read, then gives one row result
// per cycle while the output is not stalled, limited by the single registered
// read port of the font memory. Results come out of a register, so a stalled
// output only stops the back end; the front end keeps filling the queue.
// Font bytes must be written before any glyph that uses them is drawn.
module text_glyph_renderer #(
    parameter int GLYPH_HEIGHT = 8,
    parameter int MAX_COLUMNS  = 256,
    parameter int MAX_ROWS     = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first, char_code, font_addr, font_data
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pixel_x, pixel_y, row_bits, extent_w, extent_h, color
    output logic        m_tuser,   // row_valid
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic                draw_enable_reg;
    logic [31:0]         ink_color_reg;
    logic                q_push, q_full, q_pop, q_empty;
    tgr_pkg::tgr_entry_t q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_enable_reg <= 1'b1;
            ink_color_reg   <= 32'hFFFF_FFFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tgr_pkg::CFG_DRAW_ENABLE: draw_enable_reg <= cfg_wdata[0];
                tgr_pkg::CFG_INK_COLOR:   ink_color_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tgr_front #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .draw_enable (draw_enable_reg),
        .q_full      (q_full),
        .push        (q_push),
        .push_entry  (q_in)
    );

    tgr_queue #(
        .DEPTH(4)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    tgr_back #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .ink_color (ink_color_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: hw/rtl/tgr_checker.sv
`include "text_glyph_renderer_macros.svh"

module tgr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic [11:0] px_right;

    assign px_right = {1'b0, m_tdata[10:0]} + 12'(tgr_pkg::GLYPH_W);

    // hold a stalled word
    `TGR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output word changed")

    // an extent-only word carries no pixels and closes its character
    `TGR_ASSERT_NOW(a_extent_form, m_tvalid && !m_tuser, m_tlast && (m_tdata[29:0] == 30'd0), "extent-only word malformed")

    // a drawn glyph row always lies inside the reported extents
    `TGR_ASSERT_NOW(a_row_in_width, m_tvalid && m_tuser, m_tdata[41:30] >= px_right, "glyph row beyond text width")

    `TGR_ASSERT_NOW(a_row_in_height, m_tvalid && m_tuser, m_tdata[53:42] > {1'b0, m_tdata[21:11]}, "glyph row beyond text height")

endmodule

bind text_glyph_renderer tgr_checker u_checker (.*);

// File: verif/text_glyph_renderer_tb.sv
`timescale 1ns / 1ps

module text_glyph_renderer_tb;

    localparam int GLYPH_H  = 8;
    localparam int COLS_MAX = 256;
    localparam int ROWS_MAX = 256;
    localparam int TAB_STOP = 4;

    typedef struct packed {
        logic [10:0] px;
        logic [10:0] py;
        logic [7:0]  bits;
        logic        valid;
        logic [11:0] ext_w;
        logic [11:0] ext_h;
        logic [31:0] color;
        logic        last;
    } glyph_row_t;

    class glyph_scoreboard;
        glyph_row_t  rows_due[$];
        logic [7:0]  font [2048];
        int unsigned col;
        int unsigned row;
        int unsigned ext_w;
        int unsigned ext_h;
        bit          stopped;
        bit          draw_en;
        logic [31:0] ink;
        int          errors;

        function new();
            col = 0;
            row = 0;
            ext_w = 0;
            ext_h = 0;
            stopped = 0;
            draw_en = 1;
            ink = 32'hFFFF_FFFF;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == tgr_pkg::CFG_DRAW_ENABLE) begin
                draw_en = value[0];
            end else begin
                ink = value;
            end
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // Advance the cursor and extents for one accepted word, queue its rows.
        function void note_word(logic func, logic first, logic [7:0] code,
                                logic [10:0] addr, logic [7:0] data);
            glyph_row_t  r;
            int unsigned w;
            int unsigned h;
            bit          printable;
            if (func == tgr_pkg::FUNC_FONT_WR) begin
                font[addr] = data;
                return;
            end
            if (first) begin
                col = 0;
                row = 0;
                ext_w = 0;
                ext_h = 0;
                stopped = 0;
            end
            printable = 0;
            if (!stopped) begin
                if (code == tgr_pkg::CH_NUL) begin
                    stopped = 1;
                end else begin
                    if (code == tgr_pkg::CH_LF) begin
                        if (row < ROWS_MAX - 1) row++;
                        col = 0;
                    end else if (code == tgr_pkg::CH_TAB) begin
                        col += TAB_STOP - (col % TAB_STOP);
                        if (col > COLS_MAX) col = COLS_MAX;
                    end else if (code != tgr_pkg::CH_CR) begin
                        if (col < COLS_MAX) col++;
                        printable = 1;
                    end
                    w = col * tgr_pkg::GLYPH_W;
                    h = (row + 1) * GLYPH_H;
                    if (w > tgr_pkg::EXT_MAX) w = 32'(tgr_pkg::EXT_MAX);
                    if (h > tgr_pkg::EXT_MAX) h = 32'(tgr_pkg::EXT_MAX);
                    if (w > ext_w) ext_w = w;
                    if (h > ext_h) ext_h = h;
                end
            end
            r.ext_w = ext_w[11:0];
            r.ext_h = ext_h[11:0];
            r.color = ink;
            if (printable && draw_en) begin
                for (int y = 0; y < GLYPH_H; y++) begin
                    r.px    = 11'((col - 1) * tgr_pkg::GLYPH_W);
                    r.py    = 11'(row * GLYPH_H + y);
                    r.bits  = font[11'(code * GLYPH_H + y)];
                    r.valid = 1'b1;
                    r.last  = (y == GLYPH_H - 1);
                    rows_due.push_back(r);
                end
            end else begin
                r.px    = '0;
                r.py    = '0;
                r.bits  = '0;
                r.valid = 1'b0;
                r.last  = 1'b1;
                rows_due.push_back(r);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_word(glyph_row_t got);
            glyph_row_t want;
            if (rows_due.size() == 0) begin
                report($sformatf("unexpected word %0h", got));
                return;
            end
            want = rows_due.pop_front();
            cmp("pixel_x", 32'(got.px), 32'(want.px));
            cmp("pixel_y", 32'(got.py), 32'(want.py));
            cmp("row_bits", 32'(got.bits), 32'(want.bits));
            cmp("row_valid", 32'(got.valid), 32'(want.valid));
            cmp("extent_w", 32'(got.ext_w), 32'(want.ext_w));
            cmp("extent_h", 32'(got.ext_h), 32'(want.ext_h));
            cmp("color", got.color, want.color);
            cmp("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    glyph_scoreboard sb;
    bit              calm_in;
    bit              calm_out;
    bit              draw_on;
    logic [7:0]      row_seen [256];
    bit              glyph_listed [256];
    logic [7:0]      ready_glyphs[$];

    text_glyph_renderer #(
        .GLYPH_HEIGHT(GLYPH_H),
        .MAX_COLUMNS(COLS_MAX),
        .MAX_ROWS(ROWS_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 5);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_word(input logic func, input logic first, input logic [7:0] code,
                             input logic [10:0] addr, input logic [7:0] data);
        int unsigned n;
        n = (calm_in || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        repeat (n) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, data, addr, code, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(func, first, code, addr, data);
    endtask

    // Unused fields carry random junk.
    task automatic render(input logic first, input logic [7:0] code);
        send_word(tgr_pkg::FUNC_RENDER, first, code, 11'($urandom), 8'($urandom));
    endtask

    task automatic font_write(input logic [10:0] addr, input logic [7:0] data);
        row_seen[addr[10:3]][addr[2:0]] = 1'b1;
        if (row_seen[addr[10:3]] == 8'hFF && !glyph_listed[addr[10:3]]) begin
            glyph_listed[addr[10:3]] = 1'b1;
            ready_glyphs.push_back(addr[10:3]);
        end
        send_word(tgr_pkg::FUNC_FONT_WR, 1'($urandom), 8'($urandom), addr, data);
    endtask

    task automatic load_glyph(input logic [7:0] code);
        for (int y = 0; y < GLYPH_H; y++) font_write({code, 3'(y)}, 8'($urandom));
    endtask

    // A glyph is only drawn once all eight of its rows are in the font memory.
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return tgr_pkg::CH_LF;
        if (r < 17) return tgr_pkg::CH_TAB;
        if (r < 21) return tgr_pkg::CH_CR;
        if (draw_on) return ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_mode(input bit draw, input logic [31:0] ink);
        cfg_wr_en <= 1'b1;
        cfg_index <= tgr_pkg::CFG_DRAW_ENABLE;
        cfg_wdata <= {31'b0, draw};
        @(posedge aclk);
        sb.set_reg(tgr_pkg::CFG_DRAW_ENABLE, {31'b0, draw});
        cfg_index <= tgr_pkg::CFG_INK_COLOR;
        cfg_wdata <= ink;
        @(posedge aclk);
        sb.set_reg(tgr_pkg::CFG_INK_COLOR, ink);
        cfg_wr_en <= 1'b0;
        draw_on = draw;
    endtask

    // Strings: mostly short mixed text, with tab runs that saturate the column
    // and one long newline run that saturates the row.
    task automatic run_strings(input int budget, input bit tab_run, input bit row_run);
        int          done;
        int          len;
        int          kind;
        logic [7:0]  c;
        logic        first;
        done = 0;
        while (done < budget) begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                load_glyph(8'($urandom_range(1, 255)));
                done += GLYPH_H;
            end
            if (tab_run) begin
                kind = 1;
                len = $urandom_range(72, 90);
                tab_run = 0;
            end else if (row_run) begin
                kind = 2;
                len = 275;
                row_run = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                kind = 1;
                len = $urandom_range(70, 85);
            end else begin
                kind = 0;
                len = $urandom_range(1, 24);
            end
            for (int i = 0; i < len; i++) begin
                // keep the long runs in one string so they reach saturation
                first = (i == 0) || (kind == 0 && $urandom_range(0, 40) == 0);
                if (kind == 0 && $urandom_range(0, 24) == 0) begin
                    render(first, tgr_pkg::CH_NUL);
                    done++;
                    // these are ignored by the block, so they are not counted
                    repeat ($urandom_range(0, 4)) render(1'b0, 8'($urandom));
                    break;
                end
                if (kind == 1) begin
                    c = ($urandom_range(0, 4) != 0) ? tgr_pkg::CH_TAB : pick_char();
                end else if (kind == 2) begin
                    c = ($urandom_range(0, 39) != 0) ? tgr_pkg::CH_LF : pick_char();
                end else begin
                    c = pick_char();
                end
                if (kind != 2 && $urandom_range(0, 15) == 0) begin
                    font_write(11'($urandom), 8'($urandom));
                    done++;
                end
                render(first, c);
                done++;
            end
        end
    endtask

    initial begin
        int unsigned stall;
        glyph_row_t  got;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.px    = m_tdata[10:0];
                got.py    = m_tdata[21:11];
                got.bits  = m_tdata[29:22];
                got.ext_w = m_tdata[41:30];
                got.ext_h = m_tdata[53:42];
                got.color = m_tdata[85:54];
                got.valid = m_tuser;
                got.last  = m_tlast;
                sb.check_word(got);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!calm_out && $urandom_range(0, 4) == 0) stall = gap_len();
            end
        end
    end

    initial begin
        sb = new();
        calm_in = 0;
        calm_out = 0;
        draw_on = 1;
        foreach (row_seen[i]) row_seen[i] = '0;
        foreach (glyph_listed[i]) glyph_listed[i] = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= tgr_pkg::CFG_DRAW_ENABLE;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Font set-up, with the extremes of address and data.
        font_write(11'h000, 8'hFF);
        font_write(11'h7F8, 8'h00);
        font_write(11'h7F9, 8'hFF);
        font_write(11'h7FA, 8'h80);
        font_write(11'h7FB, 8'h01);
        for (int y = 4; y < GLYPH_H; y++) font_write({8'hFF, 3'(y)}, 8'($urandom));
        load_glyph(8'h41);
        load_glyph(8'h01);
        load_glyph(8'h7F);
        load_glyph(8'h80);

        // Directed text under the reset settings.
        render(1'b1, 8'h41);
        render(1'b0, 8'hFF);
        render(1'b0, 8'h80);
        render(1'b0, 8'h01);
        render(1'b0, 8'h7F);
        render(1'b0, tgr_pkg::CH_TAB);
        render(1'b0, tgr_pkg::CH_CR);
        render(1'b0, tgr_pkg::CH_LF);
        render(1'b0, 8'h41);
        render(1'b0, tgr_pkg::CH_NUL);
        render(1'b0, 8'h41);
        render(1'b0, tgr_pkg::CH_LF);
        render(1'b1, tgr_pkg::CH_TAB);
        render(1'b0, 8'hFF);
        render(1'b1, tgr_pkg::CH_NUL);
        render(1'b0, 8'hFF);
        render(1'b1, 8'h01);
        render(1'b0, tgr_pkg::CH_TAB);
        render(1'b0, tgr_pkg::CH_TAB);
        drain();

        set_mode(1'b1, 32'h0000_0000);
        run_strings(40, 1'b1, 1'b0);
        drain();
        set_mode(1'b0, $urandom);
        run_strings(30, 1'b0, 1'b0);
        drain();
        set_mode(1'b1, $urandom);
        run_strings(200, 1'b0, 1'b1);
        drain();

        if (sb.pending() != 0) sb.report("rows still expected at the end");
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
